### rtl/duration_text_to_ticks_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef DURATION_TEXT_TO_TICKS_UNIT_ASSERT_SVH
`define DURATION_TEXT_TO_TICKS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DTT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dtt_pkg.sv
package dtt_pkg;

  // Field widths
  localparam int unsigned LEAD_W   = 30;
  localparam int unsigned MINSEC_W = 7;
  localparam int unsigned MICRO_W  = 20;
  localparam int unsigned DLEFT_W  = 4;
  localparam int unsigned TICKS_W  = 64;

  // Defaults for the top-level parameters
  localparam int unsigned LEAD_DIGITS_DEF     = 9;
  localparam int unsigned FRACTION_DIGITS_DEF = 6;
  localparam int unsigned MINSEC_DIGITS       = 2;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'd0;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_COLON = 8'd58;

  typedef enum logic [3:0] {
    PH_SKIP,
    PH_DAYS,
    PH_HOURS,
    PH_MINUTES,
    PH_SECONDS,
    PH_FRACTION,
    PH_TAIL
  } dtt_phase_t;

  // Parsed fields of one finished string, handed to the scaling pipeline
  typedef struct packed {
    logic                err;
    logic                neg;
    logic [LEAD_W-1:0]   day;
    logic [LEAD_W-1:0]   hour;
    logic [MINSEC_W-1:0] minute;
    logic [MINSEC_W-1:0] second;
    logic [MICRO_W-1:0]  micro;
  } dtt_fields_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // Scale factor that right-pads the fraction
  function automatic logic [MICRO_W-1:0] pow10(input logic [DLEFT_W-1:0] n);
    logic [MICRO_W-1:0] p;
    case (n)
      4'd0: p = 20'd1;
      4'd1: p = 20'd10;
      4'd2: p = 20'd100;
      4'd3: p = 20'd1000;
      4'd4: p = 20'd10000;
      4'd5: p = 20'd100000;
      4'd6: p = 20'd1000000;
      default: p = 20'd1;
    endcase
    return p;
  endfunction

endpackage

### rtl/dtt_parser.sv
module dtt_parser
  import dtt_pkg::*;
#(
  parameter int unsigned LEAD_DIGITS     = LEAD_DIGITS_DEF,
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_take,
  input  logic [7:0]  text_byte,
  output dtt_fields_t fields
);

  localparam logic [DLEFT_W-1:0] LeadInit   = DLEFT_W'(LEAD_DIGITS);
  localparam logic [DLEFT_W-1:0] FracInit   = DLEFT_W'(FRACTION_DIGITS);
  localparam logic [DLEFT_W-1:0] MinsecInit = DLEFT_W'(MINSEC_DIGITS);

  dtt_phase_t          phase_r, phase_nxt;
  logic                neg_r, neg_nxt;
  logic                failed_r, failed_nxt;
  logic [LEAD_W-1:0]   day_r, day_nxt;
  logic [LEAD_W-1:0]   hour_r, hour_nxt;
  logic [MINSEC_W-1:0] minute_r, minute_nxt;
  logic [MINSEC_W-1:0] second_r, second_nxt;
  logic [MICRO_W-1:0]  micro_r, micro_nxt;
  logic [DLEFT_W-1:0]  dleft_r, dleft_nxt;

  logic                dig, spc, days_go;
  logic [3:0]          dval;
  logic [DLEFT_W-1:0]  days_dl;
  logic [MICRO_W-1:0]  micro_pad;

  assign dig       = is_digit(text_byte);
  assign spc       = is_space(text_byte);
  assign dval      = text_byte[3:0];
  // Outside the fraction phase either the fraction is empty or already padded
  assign micro_pad = MICRO_W'(micro_r * pow10(dleft_r));

  // Per-character state update
  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    failed_nxt = failed_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    micro_nxt  = micro_r;
    dleft_nxt  = dleft_r;
    days_go    = 1'b0;
    days_dl    = dleft_r;
    if (byte_take) begin
      if (text_byte == CH_NUL) begin
        // terminator: result leaves, state returns to reset
        phase_nxt  = PH_SKIP;
        neg_nxt    = 1'b0;
        failed_nxt = 1'b0;
        day_nxt    = '0;
        hour_nxt   = '0;
        minute_nxt = '0;
        second_nxt = '0;
        micro_nxt  = '0;
        dleft_nxt  = '0;
      end else if (!failed_r) begin
        case (phase_r)
          PH_SKIP: begin
            if (!spc) begin
              phase_nxt = PH_DAYS;
              dleft_nxt = LeadInit;
              if (text_byte == CH_MINUS) begin
                neg_nxt = 1'b1;
              end else if (text_byte != CH_PLUS) begin
                days_go = 1'b1;
                days_dl = LeadInit;
              end
            end
          end
          PH_DAYS: begin
            days_go = 1'b1;
          end
          PH_HOURS: begin
            if (dig && dleft_r != '0) begin
              hour_nxt  = LEAD_W'(hour_r * LEAD_W'(10)) + LEAD_W'(dval);
              dleft_nxt = dleft_r - 1'b1;
            end else if (text_byte == CH_COLON) begin
              phase_nxt = PH_MINUTES;
              dleft_nxt = MinsecInit;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_MINUTES: begin
            if (dig && dleft_r != '0) begin
              minute_nxt = MINSEC_W'(minute_r * MINSEC_W'(10)) + MINSEC_W'(dval);
              dleft_nxt  = dleft_r - 1'b1;
            end else if (text_byte == CH_COLON) begin
              phase_nxt = PH_SECONDS;
              dleft_nxt = MinsecInit;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_SECONDS: begin
            if (dig && dleft_r != '0) begin
              second_nxt = MINSEC_W'(second_r * MINSEC_W'(10)) + MINSEC_W'(dval);
              dleft_nxt  = dleft_r - 1'b1;
            end else if (text_byte == CH_DOT) begin
              phase_nxt = PH_FRACTION;
              dleft_nxt = FracInit;
            end else begin
              failed_nxt = 1'b1;
            end
          end
          PH_FRACTION: begin
            if (dig && dleft_r != '0) begin
              micro_nxt = MICRO_W'(micro_r * MICRO_W'(10)) + MICRO_W'(dval);
              dleft_nxt = dleft_r - 1'b1;
            end else begin
              micro_nxt = micro_pad;
              dleft_nxt = '0;
              phase_nxt = PH_TAIL;
            end
          end
          default: begin
          end
        endcase
        // First number: days if a space follows, hours if a colon follows
        if (days_go) begin
          if (dig && days_dl != '0) begin
            day_nxt   = LEAD_W'(day_r * LEAD_W'(10)) + LEAD_W'(dval);
            dleft_nxt = days_dl - 1'b1;
          end else if (spc) begin
            phase_nxt = PH_HOURS;
            dleft_nxt = LeadInit;
          end else begin
            hour_nxt = day_r;
            day_nxt  = '0;
            if (text_byte == CH_COLON) begin
              phase_nxt = PH_MINUTES;
              dleft_nxt = MinsecInit;
            end else begin
              failed_nxt = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_SKIP;
      neg_r    <= 1'b0;
      failed_r <= 1'b0;
      day_r    <= '0;
      hour_r   <= '0;
      minute_r <= '0;
      second_r <= '0;
      micro_r  <= '0;
      dleft_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      failed_r <= failed_nxt;
      day_r    <= day_nxt;
      hour_r   <= hour_nxt;
      minute_r <= minute_nxt;
      second_r <= second_nxt;
      micro_r  <= micro_nxt;
      dleft_r  <= dleft_nxt;
    end
  end

  // Fields as seen by a terminator arriving now
  always_comb begin
    fields.err    = failed_r || phase_r == PH_SKIP || phase_r == PH_DAYS ||
                    phase_r == PH_HOURS;
    fields.neg    = neg_r;
    fields.day    = day_r;
    fields.hour   = hour_r;
    fields.minute = minute_r;
    fields.second = second_r;
    fields.micro  = micro_pad;
  end

endmodule

### rtl/dtt_scale.sv
module dtt_scale
  import dtt_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_go,
  input  dtt_fields_t                in_f,
  output logic                       ready,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [TICKS_W-1:0]  out_ticks,
  output logic                       out_parse_error
);

  localparam int unsigned T2_W = LEAD_W + 5;
  localparam int unsigned T3_W = T2_W + 6;
  localparam int unsigned T4_W = T3_W + 6;

  // Stage valid bits and load enables
  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  // Stage payloads
  dtt_fields_t         s1_r;
  logic                e2_r, n2_r, e3_r, n3_r, e4_r, n4_r, e5_r, n5_r;
  logic [T2_W-1:0]     t2_r;
  logic [T3_W-1:0]     t3_r;
  logic [T4_W-1:0]     t4_r;
  logic [TICKS_W-1:0]  t5_r;
  logic [MINSEC_W-1:0] m2_r, sec2_r, sec3_r;
  logic [MICRO_W-1:0]  u2_r, u3_r, u4_r;
  logic [TICKS_W-1:0]  ticks_r;
  logic                perr_r;

  logic [T2_W-1:0]     d_ext;
  logic [T3_W-1:0]     t2_ext;
  logic [T4_W-1:0]     t3_ext;
  logic [TICKS_W-1:0]  t4_ext, t5_ext;
  logic [T2_W-1:0]     t2_nxt;
  logic [T3_W-1:0]     t3_nxt;
  logic [T4_W-1:0]     t4_nxt;
  logic [TICKS_W-1:0]  t5_nxt, t6_nxt;

  // A stage loads when empty or when its item moves on
  assign ld6   = !v6_r || !out_stall;
  assign ld5   = !v5_r || ld6;
  assign ld4   = !v4_r || ld5;
  assign ld3   = !v3_r || ld4;
  assign ld2   = !v2_r || ld3;
  assign ld1   = !v1_r || ld2;
  assign ready = ld1;

  // days*24 + hours
  assign d_ext  = T2_W'(s1_r.day);
  assign t2_nxt = (d_ext << 4) + (d_ext << 3) + T2_W'(s1_r.hour);
  // *60 + minutes
  assign t2_ext = T3_W'(t2_r);
  assign t3_nxt = (t2_ext << 6) - (t2_ext << 2) + T3_W'(m2_r);
  // *60 + seconds
  assign t3_ext = T4_W'(t3_r);
  assign t4_nxt = (t3_ext << 6) - (t3_ext << 2) + T4_W'(sec3_r);
  // *1000000 + micro, wrapping at 64 bits
  assign t4_ext = TICKS_W'(t4_r);
  assign t5_nxt = (t4_ext << 20) - (t4_ext << 16) + (t4_ext << 14) + (t4_ext << 9) +
                  (t4_ext << 6) + TICKS_W'(u4_r);
  // *10, then sign and error
  assign t5_ext = (t5_r << 3) + (t5_r << 1);
  assign t6_nxt = e5_r ? '0 : (n5_r ? ('0 - t5_ext) : t5_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_go;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
      if (ld4) v4_r <= v3_r;
      if (ld5) v5_r <= v4_r;
      if (ld6) v6_r <= v5_r;
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (ld1) s1_r <= in_f;
    if (ld2) begin
      e2_r   <= s1_r.err;
      n2_r   <= s1_r.neg;
      t2_r   <= t2_nxt;
      m2_r   <= s1_r.minute;
      sec2_r <= s1_r.second;
      u2_r   <= s1_r.micro;
    end
    if (ld3) begin
      e3_r   <= e2_r;
      n3_r   <= n2_r;
      t3_r   <= t3_nxt;
      sec3_r <= sec2_r;
      u3_r   <= u2_r;
    end
    if (ld4) begin
      e4_r <= e3_r;
      n4_r <= n3_r;
      t4_r <= t4_nxt;
      u4_r <= u3_r;
    end
    if (ld5) begin
      e5_r <= e4_r;
      n5_r <= n4_r;
      t5_r <= t5_nxt;
    end
    if (ld6) begin
      ticks_r <= t6_nxt;
      perr_r  <= e5_r;
    end
  end

  assign out_valid       = v6_r;
  assign out_ticks       = ticks_r;
  assign out_parse_error = perr_r;

endmodule

### rtl/duration_text_to_ticks_unit.sv
// Duration text parser: converts a "[+|-][D ]HH:MM[:SS[.ffffff]]" string to 100 ns ticks.
// Input channel: in_valid / in_stall with one character per item on in_text_byte.
// A zero byte ends the string and produces exactly one result item; every other
// byte produces none. Result channel: out_valid / out_stall with out_ticks (signed,
// wraps modulo 2^64) and out_parse_error (ticks is 0 when set).
// Throughput: one character per cycle while in_stall is low, terminators included. Each
// taken character updates the parser registers; a terminator then travels a six-register
// scaling pipeline (capture, then the *24, *60, *60, *1e6 and *10-with-sign steps).
// out_valid rises once the result has reached the last pipeline register. Reset
// (rst_n low, synchronous) returns the parser to skipping leading white space
// and empties the pipeline. When the receiver stalls, the result holds and the
// pipeline keeps taking items until every stage is full; in_stall then rises and
// stays up until the output moves.
module duration_text_to_ticks_unit
  import dtt_pkg::*;
#(
  parameter int unsigned LEAD_DIGITS     = LEAD_DIGITS_DEF,
  parameter int unsigned FRACTION_DIGITS = FRACTION_DIGITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [7:0]                in_text_byte,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [TICKS_W-1:0] out_ticks,
  output logic                      out_parse_error
);

  logic        take, term, pipe_ready;
  dtt_fields_t fields;

  // Item handshake
  assign in_stall = !pipe_ready;
  assign take     = in_valid && !in_stall;
  assign term     = take && (in_text_byte == CH_NUL);

  dtt_parser #(
    .LEAD_DIGITS     (LEAD_DIGITS),
    .FRACTION_DIGITS (FRACTION_DIGITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (take),
    .text_byte (in_text_byte),
    .fields    (fields)
  );

  dtt_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_go           (term),
    .in_f            (fields),
    .ready           (pipe_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_ticks       (out_ticks),
    .out_parse_error (out_parse_error)
  );

endmodule

### rtl/dtt_checker.sv
`include "duration_text_to_ticks_unit_assert.svh"

module dtt_checker
  import dtt_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [TICKS_W-1:0] out_ticks,
  input logic                      out_parse_error
);

  // An error result always carries zero ticks
  `DTT_ASSERT_NOW(a_err_zero, out_valid && out_parse_error, out_ticks == '0,
                  "error result with nonzero ticks")

  // Input backs up only when a result is waiting on a stalled receiver
  `DTT_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall,
                  "input stalled while output is free")

  // A stalled result holds its value
  `DTT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
                   out_valid && $stable(out_ticks) && $stable(out_parse_error),
                   "stalled result changed")

endmodule

bind duration_text_to_ticks_unit dtt_checker u_dtt_checker (.*);

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dtt_pkg::*;

  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int unsigned RANDOM_BYTES = 1200;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned REPORT_LIMIT = 10;
  localparam int unsigned N_DIRECTED   = 16;

  // Parses the character stream on its own and holds the tick counts still owed.
  class ticks_board;
    typedef struct {
      logic signed [TICKS_W-1:0] ticks;
      logic                      parse_error;
    } tick_result_t;

    dtt_phase_t          phase;
    bit                  neg;
    bit [LEAD_W-1:0]     days;
    bit [LEAD_W-1:0]     hours;
    bit [MINSEC_W-1:0]   mins;
    bit [MINSEC_W-1:0]   secs;
    bit [MICRO_W-1:0]    micro;
    int unsigned         left;
    bit                  bad;
    tick_result_t        owed_ticks_q[$];
    int unsigned         mismatches;

    function new();
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      phase = PH_SKIP;
      neg   = 1'b0;
      days  = '0;
      hours = '0;
      mins  = '0;
      secs  = '0;
      micro = '0;
      left  = 0;
      bad   = 1'b0;
    endfunction

    function bit blank(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= 8'd13);
    endfunction

    function bit numeral(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function int pending();
      return owed_ticks_q.size();
    endfunction

    // right-pad the fraction to microseconds
    function void pad_micro();
      while (left > 0) begin
        micro = micro * 10;
        left--;
      end
    endfunction

    // first number: days if a blank follows, else the hours
    function void first_number(logic [7:0] c);
      if (numeral(c) && left > 0) begin
        days = days * 10 + (c - CH_ZERO);
        left--;
      end else if (blank(c)) begin
        phase = PH_HOURS;
        left  = LEAD_DIGITS_DEF;
      end else begin
        hours = days;
        days  = '0;
        if (c == CH_COLON) begin
          phase = PH_MINUTES;
          left  = MINSEC_DIGITS;
        end else begin
          bad = 1'b1;
        end
      end
    endfunction

    function void parse_char(logic [7:0] c);
      case (phase)
        PH_SKIP: begin
          if (!blank(c)) begin
            phase = PH_DAYS;
            left  = LEAD_DIGITS_DEF;
            if (c == CH_MINUS) neg = 1'b1;
            else if (c != CH_PLUS) first_number(c);
          end
        end
        PH_DAYS: first_number(c);
        PH_HOURS: begin
          if (numeral(c) && left > 0) begin
            hours = hours * 10 + (c - CH_ZERO);
            left--;
          end else if (c == CH_COLON) begin
            phase = PH_MINUTES;
            left  = MINSEC_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        PH_MINUTES: begin
          if (numeral(c) && left > 0) begin
            mins = mins * 10 + (c - CH_ZERO);
            left--;
          end else if (c == CH_COLON) begin
            phase = PH_SECONDS;
            left  = MINSEC_DIGITS;
          end else begin
            bad = 1'b1;
          end
        end
        PH_SECONDS: begin
          if (numeral(c) && left > 0) begin
            secs = secs * 10 + (c - CH_ZERO);
            left--;
          end else if (c == CH_DOT) begin
            phase = PH_FRACTION;
            left  = FRACTION_DIGITS_DEF;
          end else begin
            bad = 1'b1;
          end
        end
        PH_FRACTION: begin
          if (numeral(c) && left > 0) begin
            micro = micro * 10 + (c - CH_ZERO);
            left--;
          end else begin
            pad_micro();
            phase = PH_TAIL;
          end
        end
        default: ;
      endcase
    endfunction

    // called for every accepted item; the terminator queues one result
    function void note_char(logic [7:0] c);
      tick_result_t want;
      logic [TICKS_W-1:0] total;
      if (c != CH_NUL) begin
        if (!bad) parse_char(c);
        return;
      end
      want.parse_error = bad || phase inside {PH_SKIP, PH_DAYS, PH_HOURS};
      total = '0;
      if (!want.parse_error) begin
        if (phase == PH_FRACTION) pad_micro();
        total = TICKS_W'(days) * 24 + TICKS_W'(hours);
        total = total * 60 + TICKS_W'(mins);
        total = total * 60 + TICKS_W'(secs);
        total = total * 1000000 + TICKS_W'(micro);
        total = total * 10;
        if (neg) total = -total;
      end
      want.ticks = total;
      owed_ticks_q.push_back(want);
      clear();
    endfunction

    function void check_result(logic signed [TICKS_W-1:0] ticks, logic parse_error);
      tick_result_t want;
      if (owed_ticks_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: ticks %0d parse_error %0b", ticks, parse_error);
        return;
      end
      want = owed_ticks_q.pop_front();
      if (ticks !== want.ticks || parse_error !== want.parse_error) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("mismatch: ticks exp %0d got %0d, parse_error exp %0b got %0b",
                   want.ticks, ticks, want.parse_error, parse_error);
      end
    endfunction
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [7:0]                in_text_byte = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [TICKS_W-1:0] out_ticks;
  logic                      out_parse_error;

  ticks_board board = new();
  logic [7:0] text_q[$];
  bit tx_quiet = 1'b0;
  int unsigned stuck_cycles = 0;

  string directed_text [N_DIRECTED] = '{
    "",
    " \011\012\013\014\015",
    "-999999999 999999999:99:99.999999",
    "+0 0:0",
    "\015 -12:34:56",
    ":",
    "7 23",
    "5",
    "1:2:3.4x\377 ",
    "1234567890:00",
    "1:123",
    "1:2:3.1234567",
    "1x2:3",
    "3 4:5:6.",
    "-+1:0",
    "200\200:1"
  };

  always #6 clk = ~clk;

  duration_text_to_ticks_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_text_byte   (in_text_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ticks      (out_ticks),
    .out_parse_error(out_parse_error)
  );

  // Monitor both channels and watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles = 0;
      else stuck_cycles++;
      if (in_valid && !in_stall) board.note_char(in_text_byte);
      if (out_valid && !out_stall) board.check_result(out_ticks, out_parse_error);
      if (stuck_cycles == STUCK_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stall before each item, with quiet stretches
  initial begin : result_sink
    int unsigned hold;
    bit quiet;
    quiet = 1'b0;
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 63) == 0) quiet = !quiet;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 63) == 0) tx_quiet = !tx_quiet;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_text_byte <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  // Hold the input until every owed result has come out
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  function automatic void push_digits(int unsigned n, bit nines);
    repeat (n) text_q.push_back(nines ? CH_NINE : CH_ZERO + 8'($urandom_range(0, 9)));
  endfunction

  // tab, LF, VT, FF, CR or space
  function automatic void push_blank();
    int unsigned r;
    r = $urandom_range(0, 5);
    text_q.push_back(r == 5 ? CH_SPACE : CH_TAB + 8'(r));
  endfunction

  // Full width a quarter of the time, sometimes one digit too many, else shorter
  function automatic int unsigned lead_len();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r < 4) return LEAD_DIGITS_DEF;
    if (r == 4) return LEAD_DIGITS_DEF + 1;
    return $urandom_range(0, LEAD_DIGITS_DEF - 1);
  endfunction

  function automatic int unsigned short_len(int unsigned max_digits);
    if ($urandom_range(0, 9) == 0) return max_digits + 1;
    return $urandom_range(0, max_digits);
  endfunction

  // One random string: mostly well formed, some noise and damaged ones
  function automatic void build_string();
    int unsigned kind;
    int unsigned pos;
    int unsigned sign;
    bit nines;
    text_q.delete();
    kind  = $urandom_range(0, 9);
    nines = ($urandom_range(0, 7) == 0);
    if (kind == 0) begin
      repeat ($urandom_range(0, 8)) text_q.push_back(8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 2) == 0) repeat ($urandom_range(1, 3)) push_blank();
      sign = $urandom_range(0, 2);
      if (sign == 1) text_q.push_back(CH_PLUS);
      if (sign == 2) text_q.push_back(CH_MINUS);
      if ($urandom_range(0, 1) == 1) begin
        push_digits(lead_len(), nines);
        push_blank();
      end
      push_digits(lead_len(), nines);
      text_q.push_back(CH_COLON);
      push_digits(short_len(MINSEC_DIGITS), nines);
      if ($urandom_range(0, 2) != 0) begin
        text_q.push_back(CH_COLON);
        push_digits(short_len(MINSEC_DIGITS), nines);
        if ($urandom_range(0, 2) != 0) begin
          text_q.push_back(CH_DOT);
          push_digits(short_len(FRACTION_DIGITS_DEF), nines);
        end
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(1, 255)));
      // damage a few: overwrite, drop or cut short
      if (kind >= 8 && text_q.size() > 0) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: text_q[pos] = 8'($urandom_range(1, 255));
          1: text_q.delete(pos);
          default: while (text_q.size() > pos) void'(text_q.pop_back());
        endcase
      end
    end
    text_q.push_back(CH_NUL);
  endfunction

  // Main sequence
  initial begin
    int unsigned bytes_sent;
    bytes_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_text[i]) send_line(directed_text[i]);
    drain_results();

    while (bytes_sent < RANDOM_BYTES) begin
      build_string();
      foreach (text_q[i]) send_byte(text_q[i]);
      bytes_sent += text_q.size();
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    in_valid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (board.mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

### duration_text_to_ticks_unit.f
+incdir+rtl
rtl/dtt_pkg.sv
rtl/dtt_parser.sv
rtl/dtt_scale.sv
rtl/duration_text_to_ticks_unit.sv
rtl/dtt_checker.sv
sim/tb.sv
